// ===== hdl/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and codes of the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // bitmap word: pages held per memory word
  localparam int WORD_W = 32;
  localparam int OFF_W  = 5;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_MARK  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_WRITE,
    S_SEEK_START,
    S_SEEK,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clr_write;
    logic latch;
    logic wr_op;
    logic seek_start;
    logic seek_step;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic reject;
    logic is_free;
    logic hint_full;
    logic seek_end;
  } dp_status_t;

endpackage

// ===== hdl/bpa_ram.sv =====
// ----------------------------------------------------------------------------
// bpa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/bpa_dp.sv =====
// ----------------------------------------------------------------------------
// bpa_dp
// Datapath: bitmap memory, next-free hint, word scan and result registers.
// ----------------------------------------------------------------------------
module bpa_dp import bpa_pkg::*; #(
  parameter int NUM_PAGES = 1024
) (
  input  logic       clk,
  input  logic       rst,
  input  dp_cmd_t    ctl,
  output dp_status_t st,
  input  logic [1:0] cmd,
  input  logic [9:0] page_id,
  output logic [9:0] result_page,
  output logic [1:0] status
);

  localparam int HW        = $clog2(NUM_PAGES + 1);
  localparam int NUM_WORDS = (NUM_PAGES + WORD_W - 1) / WORD_W;
  localparam int WAW       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int TAIL      = NUM_PAGES % WORD_W;
  localparam logic [WAW-1:0] LAST_WORD = WAW'(NUM_WORDS - 1);
  localparam logic [HW-1:0]  FULL_HINT = HW'(NUM_PAGES);
  localparam logic [WORD_W-1:0] LAST_MASK =
    (TAIL == 0) ? {WORD_W{1'b1}} : WORD_W'((64'(1) << TAIL) - 64'(1));

  logic [HW-1:0]     hint;
  logic [HW-1:0]     op_page;
  logic [1:0]        op_cmd;
  logic [1:0]        res_status;
  logic [9:0]        res_page;
  logic [WAW-1:0]    clr_word;
  logic [WAW-1:0]    scan_word;

  logic              ram_we;
  logic [WAW-1:0]    ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WAW-1:0]    ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic [WAW-1:0]    op_word;
  logic [WAW-1:0]    hint_word;
  logic [WORD_W-1:0] op_bit;
  logic [WORD_W-1:0] clr_pattern;
  logic [WORD_W-1:0] scan_bits;
  logic [OFF_W-1:0]  scan_pos;
  logic              scan_found;
  logic              pid_ok;
  logic              hint_full;

  assign op_word   = WAW'(op_page >> OFF_W);
  assign hint_word = WAW'(hint >> OFF_W);
  assign op_bit    = WORD_W'(1) << OFF_W'(op_page);
  assign hint_full = (hint == FULL_HINT);
  assign pid_ok    = (32'(page_id) < 32'(NUM_PAGES));

  // reset image: page zero used, pages past the end never free
  always_comb begin
    clr_pattern = {WORD_W{1'b1}};
    if (clr_word == LAST_WORD) begin
      clr_pattern = clr_pattern & LAST_MASK;
    end
    if (clr_word == '0) begin
      clr_pattern[0] = 1'b0;
    end
  end

  // lowest free page in the word under scan, ignoring pages below the hint
  always_comb begin
    scan_bits = ram_rdata;
    if (scan_word == hint_word) begin
      scan_bits = ram_rdata & ~((WORD_W'(1) << OFF_W'(hint)) - WORD_W'(1));
    end
    scan_found = |scan_bits;
    scan_pos   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (scan_bits[i]) begin
        scan_pos = OFF_W'(i);
      end
    end
  end

  always_comb begin
    ram_we    = ctl.clr_write || ctl.wr_op;
    ram_waddr = ctl.clr_write ? clr_word : op_word;
    if (ctl.clr_write) begin
      ram_wdata = clr_pattern;
    end else if (op_cmd == CMD_FREE) begin
      ram_wdata = ram_rdata | op_bit;
    end else begin
      ram_wdata = ram_rdata & ~op_bit;
    end
    if (ctl.seek_step) begin
      ram_raddr = scan_word + WAW'(1);
    end else if (ctl.seek_start) begin
      ram_raddr = hint_word;
    end else begin
      ram_raddr = op_word;
    end
  end

  bpa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hint     <= HW'(1);
      clr_word <= '0;
    end else begin
      if (ctl.clr_write) begin
        clr_word <= clr_word + WAW'(1);
      end
      if (ctl.wr_op && op_cmd == CMD_FREE && op_page < hint) begin
        hint <= op_page;
      end
      if (ctl.seek_step && scan_found) begin
        hint <= HW'({scan_word, scan_pos});
      end else if (ctl.seek_step && scan_word == LAST_WORD) begin
        hint <= FULL_HINT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      op_cmd   <= cmd;
      op_page  <= (cmd == CMD_ALLOC) ? hint : HW'(page_id);
      res_page <= (cmd == CMD_ALLOC && !hint_full) ? 10'(hint) : 10'd0;
      case (cmd)
        CMD_ALLOC: res_status <= hint_full ? ST_FULL : ST_OK;
        CMD_FREE:  res_status <= (page_id == '0 || !pid_ok) ? ST_BAD : ST_OK;
        CMD_MARK:  res_status <= pid_ok ? ST_OK : ST_BAD;
        default:   res_status <= ST_BAD;
      endcase
    end
    if (ctl.seek_start) begin
      scan_word <= hint_word;
    end else if (ctl.seek_step) begin
      scan_word <= scan_word + WAW'(1);
    end
    if (ctl.load_out) begin
      result_page <= res_page;
      status      <= res_status;
    end
  end

  assign st.clr_last  = (clr_word == LAST_WORD);
  assign st.reject    = (res_status != ST_OK);
  assign st.is_free   = (op_cmd == CMD_FREE);
  assign st.hint_full = hint_full;
  assign st.seek_end  = scan_found || (scan_word == LAST_WORD);

endmodule

// ===== hdl/bpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpa_ctrl
// Controller: clearing pass, command sequencing and output handshake.
// ----------------------------------------------------------------------------
module bpa_ctrl import bpa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output dp_cmd_t    ctl,
  input  dp_status_t st
);

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_stall   = 1'b1;
    case (state)
      S_CLEAR: begin
        ctl.clr_write = 1'b1;
        if (st.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.latch  = 1'b1;
          state_next = S_CHECK;
        end
      end
      // bitmap word read is issued here
      S_CHECK: begin
        state_next = st.reject ? S_DONE : S_WRITE;
      end
      S_WRITE: begin
        ctl.wr_op = 1'b1;
        if (st.is_free || st.hint_full) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SEEK_START;
        end
      end
      S_SEEK_START: begin
        ctl.seek_start = 1'b1;
        state_next     = S_SEEK;
      end
      S_SEEK: begin
        ctl.seek_step = 1'b1;
        if (st.seek_end) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/bitmap_page_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// Free-page bitmap allocator with a next-free hint.
// ----------------------------------------------------------------------------
// The bitmap lives in a RAM of 32-bit words, one bit per page (1 = free).
// After reset a clearing pass writes the map, one word per cycle, and the
// block takes no item until the pass is done. One item is worked at a time.
// A free passes through check, write and done before its result; a
// rejected item goes from check straight to done. An allocate or mark-used
// writes the map and then scans upward from the hint one word per cycle
// until it finds a free page or reaches the last word, then goes to done;
// a mark-used with the map already full skips the scan. The scan runs over
// the single RAM read port. The result sits in an output register, so a
// new item is taken while it waits.
module bitmap_page_allocator import bpa_pkg::*; #(
  parameter int NUM_PAGES = 1024
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  input  logic [9:0] page_id,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [9:0] result_page,
  output logic [1:0] status
);

  dp_cmd_t    ctl;
  dp_status_t st;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl),
    .st        (st)
  );

  bpa_dp #(
    .NUM_PAGES (NUM_PAGES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .st          (st),
    .cmd         (cmd),
    .page_id     (page_id),
    .result_page (result_page),
    .status      (status)
  );

endmodule
